/* hdl/i2cms_pkg.sv */
package i2cms_pkg;

  localparam logic [2:0] FUNC_START = 3'd0;
  localparam logic [2:0] FUNC_STOP  = 3'd1;
  localparam logic [2:0] FUNC_SEND  = 3'd2;
  localparam logic [2:0] FUNC_WACK  = 3'd3;
  localparam logic [2:0] FUNC_READ  = 3'd4;

  localparam logic       CFG_BIT_DELAY   = 1'b0;
  localparam logic       CFG_ACK_TIMEOUT = 1'b1;

  localparam logic [15:0] BIT_DELAY_RST   = 16'd120;
  localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd250;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_START0, ST_START1, ST_START2,
    ST_STOP0, ST_STOP1, ST_STOP2,
    ST_TX0, ST_TX1, ST_TX2,
    ST_ACK0, ST_ACK1,
    ST_ASTOP0, ST_ASTOP1, ST_ASTOP2, ST_ALAST,
    ST_RX0, ST_RX1,
    ST_RACK0, ST_RACK1, ST_RACK2, ST_RACK3
  } state_t;

  // One request per phase from the controller to the datapath.
  typedef struct packed {
    logic load;        // latch the accepted command's operands
    logic start;       // begin a phase
    logic set_scl;
    logic scl_val;
    logic set_sda;
    logic sda_val;
    logic sda_from_tx; // drive SDA from tx shift MSB
    logic shift_tx;
    logic sample_rx;
    logic count_bit;
    logic last;
    logic show_rx;
    logic show_noack;
  } seq_cmd_t;

  typedef struct packed {
    logic busy;
    logic last_bit;
    logic send_ack;
    logic timeout;
  } seq_stat_t;

endpackage

/* hdl/i2cms_ctrl.sv */
module i2cms_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [2:0]          func,
  input  i2cms_pkg::seq_stat_t stat,
  output i2cms_pkg::seq_cmd_t  cmd
);
  import i2cms_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    s_tready   = (state == ST_IDLE) && !stat.busy;
    if (state != ST_IDLE && !stat.busy) begin
      cmd.start = 1'b1;
    end
    case (state)
      ST_IDLE: begin
        if (s_tvalid && s_tready) begin
          cmd.load = 1'b1;
          case (func)
            FUNC_START: state_next = ST_START0;
            FUNC_STOP:  state_next = ST_STOP0;
            FUNC_SEND:  state_next = ST_TX0;
            FUNC_WACK:  state_next = ST_ACK0;
            FUNC_READ:  state_next = ST_RX0;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_START0: begin
        cmd.set_scl = 1'b1; cmd.scl_val = 1'b1;
        cmd.set_sda = 1'b1; cmd.sda_val = 1'b1;
        if (!stat.busy) state_next = ST_START1;
      end
      ST_START1: begin
        cmd.set_sda = 1'b1;
        if (!stat.busy) state_next = ST_START2;
      end
      ST_START2: begin
        cmd.set_scl = 1'b1; cmd.last = 1'b1;
        if (!stat.busy) state_next = ST_IDLE;
      end
      ST_STOP0, ST_ASTOP0: begin
        cmd.set_sda = 1'b1;
        if (!stat.busy) state_next = (state == ST_STOP0) ? ST_STOP1 : ST_ASTOP1;
      end
      ST_STOP1, ST_ASTOP1: begin
        cmd.set_scl = 1'b1; cmd.scl_val = 1'b1;
        if (!stat.busy) state_next = (state == ST_STOP1) ? ST_STOP2 : ST_ASTOP2;
      end
      ST_STOP2: begin
        cmd.set_sda = 1'b1; cmd.sda_val = 1'b1; cmd.last = 1'b1;
        if (!stat.busy) state_next = ST_IDLE;
      end
      ST_ASTOP2: begin
        cmd.set_sda = 1'b1; cmd.sda_val = 1'b1;
        if (!stat.busy) state_next = ST_ALAST;
      end
      ST_TX0: begin
        cmd.sda_from_tx = 1'b1;
        if (!stat.busy) state_next = ST_TX1;
      end
      ST_TX1: begin
        cmd.set_scl = 1'b1; cmd.scl_val = 1'b1;
        if (!stat.busy) state_next = ST_TX2;
      end
      ST_TX2: begin
        // release SDA after the last bit
        cmd.set_scl   = 1'b1;
        cmd.set_sda   = stat.last_bit; cmd.sda_val = 1'b1;
        cmd.shift_tx  = 1'b1;
        cmd.count_bit = 1'b1;
        cmd.last      = stat.last_bit;
        if (!stat.busy) state_next = stat.last_bit ? ST_IDLE : ST_TX0;
      end
      ST_ACK0: begin
        cmd.set_sda = 1'b1; cmd.sda_val = 1'b1;
        if (!stat.busy) state_next = ST_ACK1;
      end
      ST_ACK1: begin
        cmd.set_scl = 1'b1; cmd.scl_val = 1'b1;
        if (!stat.busy) state_next = stat.timeout ? ST_ASTOP0 : ST_ALAST;
      end
      ST_ALAST: begin
        cmd.set_scl = 1'b1; cmd.last = 1'b1; cmd.show_noack = 1'b1;
        if (!stat.busy) state_next = ST_IDLE;
      end
      ST_RX0: begin
        cmd.set_scl = 1'b1; cmd.scl_val = 1'b1;
        if (!stat.busy) state_next = ST_RX1;
      end
      ST_RX1: begin
        cmd.set_scl   = 1'b1;
        cmd.sample_rx = 1'b1;
        cmd.count_bit = 1'b1;
        if (!stat.busy) state_next = stat.last_bit ? ST_RACK0 : ST_RX0;
      end
      ST_RACK0: begin
        cmd.set_sda = 1'b1; cmd.sda_val = !stat.send_ack;
        if (!stat.busy) state_next = ST_RACK1;
      end
      ST_RACK1: begin
        cmd.set_scl = 1'b1; cmd.scl_val = 1'b1;
        if (!stat.busy) state_next = ST_RACK2;
      end
      ST_RACK2: begin
        cmd.set_scl = 1'b1;
        cmd.last    = !stat.send_ack;
        cmd.show_rx = !stat.send_ack;
        if (!stat.busy) state_next = stat.send_ack ? ST_RACK3 : ST_IDLE;
      end
      ST_RACK3: begin
        cmd.set_sda = 1'b1; cmd.sda_val = 1'b1;
        cmd.last    = 1'b1; cmd.show_rx = 1'b1;
        if (!stat.busy) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* hdl/i2cms_datapath.sv */
module i2cms_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic [7:0]          tx_byte,
  input  logic                send_ack,
  input  logic [7:0]          sda_bits,
  input  logic [7:0]          ack_wait,
  input  i2cms_pkg::seq_cmd_t  cmd,
  output i2cms_pkg::seq_stat_t stat,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [15:0]         m_tdata,
  output logic                m_tlast
);
  import i2cms_pkg::*;

  logic [15:0] bit_delay;
  logic [7:0]  ack_timeout;
  logic        scl_drive;
  logic        sda_drive;
  logic [7:0]  tx_sr;
  logic [7:0]  dev_sr;
  logic [7:0]  rx_sr;
  logic [2:0]  bit_cnt;
  logic        ack_flag;
  logic        timeout;
  logic [15:0] dly_cnt;
  logic        counting;
  logic        ph_last;
  logic        ph_rx;
  logic        ph_noack;
  logic        out_scl;
  logic        out_sda;
  logic [7:0]  out_rx;
  logic        out_noack;

  assign stat.busy     = counting || m_tvalid;
  assign stat.last_bit = (bit_cnt == 3'd7);
  assign stat.send_ack = ack_flag;
  assign stat.timeout  = timeout;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_delay   <= BIT_DELAY_RST;
      ack_timeout <= ACK_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BIT_DELAY:   bit_delay   <= cfg_data;
        CFG_ACK_TIMEOUT: ack_timeout <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scl_drive <= 1'b1;
      sda_drive <= 1'b1;
      counting  <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cmd.start) begin
        if (cmd.set_scl) scl_drive <= cmd.scl_val;
        if (cmd.sda_from_tx) begin
          sda_drive <= tx_sr[7];
        end else if (cmd.set_sda) begin
          sda_drive <= cmd.sda_val;
        end
        counting <= 1'b1;
      end else if (counting && dly_cnt == 16'd0) begin
        counting <= 1'b0;
        m_tvalid <= 1'b1;
      end
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tx_sr    <= tx_byte;
      dev_sr   <= sda_bits;
      rx_sr    <= 8'd0;
      bit_cnt  <= 3'd0;
      ack_flag <= send_ack;
      timeout  <= (ack_wait > ack_timeout);
    end
    if (cmd.start) begin
      if (cmd.shift_tx) tx_sr <= {tx_sr[6:0], 1'b0};
      if (cmd.sample_rx) begin
        // open drain: device bit wired-AND with our own drive
        rx_sr  <= {rx_sr[6:0], dev_sr[7] & sda_drive};
        dev_sr <= {dev_sr[6:0], 1'b0};
      end
      if (cmd.count_bit) bit_cnt <= bit_cnt + 3'd1;
      dly_cnt  <= bit_delay - 16'd1;
      ph_last  <= cmd.last;
      ph_rx    <= cmd.show_rx;
      ph_noack <= cmd.show_noack;
    end else if (counting) begin
      dly_cnt <= dly_cnt - 16'd1;
    end
    if (counting && dly_cnt == 16'd0) begin
      out_scl   <= scl_drive;
      out_sda   <= sda_drive;
      out_rx    <= ph_rx ? rx_sr : 8'd0;
      out_noack <= ph_noack & timeout;
      m_tlast   <= ph_last;
    end
  end

  assign m_tdata = {5'd0, out_noack, out_rx, out_sda, out_scl};

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> !counting && !m_tvalid)
    else $error("phase started while previous phase in flight");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !cmd.start && !stat.busy)
    else $error("command loaded while a phase is busy");

  a_start_counts: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> counting && !m_tvalid)
    else $error("phase start did not begin hold count");

  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(counting && m_tvalid))
    else $error("hold count and output request overlap");

endmodule

/* hdl/i2c_master_bit_sequencer.sv */
// I2C master bit sequencer. Each request on the s_ side is one command
// (start, stop, send byte, wait ack, read byte; other codes are dropped with no
// output) and expands into a run of bus phases, each delivered as one request
// on the m_ side with tlast on the final phase. A phase is held by the datapath
// hold counter, loaded from bit_delay, before it is offered. Start and stop run
// 3 phases, wait ack 3 (6 on timeout, with no_ack set), read byte 19 or 20,
// send byte 24. One command is in work at a time; the next is taken once the
// last phase has been delivered. Configuration: index 0 bit_delay (reset 120),
// index 1 ack_timeout (reset 250, 255 never times out).
module i2c_master_bit_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // func[2:0] tx_byte[10:3] send_ack[11]
                                 // sda_bits[19:12] ack_wait[27:20]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // scl_level[0] sda_level[1] rx_byte[9:2]
                                 // no_ack[10]
  output logic        m_tlast    // last_phase
);
  import i2cms_pkg::*;

  seq_cmd_t  cmd;
  seq_stat_t stat;

  i2cms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .func     (s_tdata[2:0]),
    .stat     (stat),
    .cmd      (cmd)
  );

  i2cms_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tx_byte   (s_tdata[10:3]),
    .send_ack  (s_tdata[11]),
    .sda_bits  (s_tdata[19:12]),
    .ack_wait  (s_tdata[27:20]),
    .cmd       (cmd),
    .stat      (stat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule
